FILE: hw/rtl/min_tracking_stack_top_assert.svh
// Assertion macros shared by the min tracking stack RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_tracking_stack: same-cycle check failed");

`define MTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_tracking_stack: next-cycle check failed");

`else

`define MTS_ASSERT_IMP(label, ante, cons)

`define MTS_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/mts_pkg.sv
package mts_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned WORD_W = 32;

  // Mode codes of an input transaction; every other code is a query.
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;

  localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] min_value;
    logic                     is_empty;
    status_t                  status;
  } out_item_t;

endpackage

FILE: hw/rtl/mts_ram.sv
module mts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/min_tracking_stack_top.sv
// Min tracking stack: a LIFO of signed 32-bit words that also reports the
// minimum of all stored words with every result.
// Input channel in_valid/in_ready/in_data carries one operation per
// transaction: push a word, pop the top, or query. Each accepted transaction
// yields exactly one result transaction on out_valid/out_ready/out_data with
// the popped word, the new top, the new minimum, an empty flag and a status.
// For push, query, a pop on an empty stack and a pop of the last entry the
// result is registered at the accepting edge. A pop that leaves entries waits
// in S_POP_WAIT, since the new top and its minimum come back from the entry
// RAM through its registered read port.
// The top word and its running minimum are cached in registers; the RAM holds
// every entry with its running minimum, written at the push address.
// A new transaction is accepted while a result waits, as long as that result
// is taken in the same cycle. A stalled receiver holds the result register and
// blocks further input until it is taken.
// Synchronous reset empties the stack and drops any pending result; no
// clearing pass is needed because only written entries are ever read.
`include "min_tracking_stack_top_assert.svh"

module min_tracking_stack_top import mts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = 2 * WORD_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] top_val_r, top_val_nxt;
  logic signed [WORD_W-1:0] top_min_r, top_min_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;

  logic [CW-1:0]            count_m2;
  logic signed [WORD_W-1:0] push_min;

  assign count_m2  = count_r - CW'(2);
  assign push_min  = ((count_r == '0) || (in_data.push_value < top_min_r)) ?
                     in_data.push_value : top_min_r;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {in_data.push_value, push_min};
  assign ram_raddr = count_m2[AW-1:0];

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic     hold_result;
    logic     empty_nxt;
    status_t  status;
    logic signed [WORD_W-1:0] popped;

    hold_result   = 1'b0;
    empty_nxt     = 1'b0;
    status        = ST_OK;
    popped        = NONE_WORD;
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_min_nxt   = top_min_r;
    popped_nxt    = popped_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.mode)
            MODE_PUSH: begin
              if (count_r == DEPTH_C) begin
                status = ST_PUSH_FULL;
              end else begin
                ram_we      = 1'b1;
                top_val_nxt = in_data.push_value;
                top_min_nxt = push_min;
                count_nxt   = count_r + CW'(1);
              end
            end
            MODE_POP: begin
              if (count_r == '0) begin
                status = ST_POP_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
                popped    = top_val_r;
                // Entries remain below the popped one, so the new top has to
                // come back from the RAM before the result can be formed.
                if (count_r != CW'(1)) begin
                  hold_result = 1'b1;
                  popped_nxt  = top_val_r;
                  state_nxt   = S_POP_WAIT;
                end
              end
            end
            default: begin
            end
          endcase

          if (!hold_result) begin
            empty_nxt            = (count_nxt == '0);
            out_nxt.popped_value = popped;
            out_nxt.top_value    = empty_nxt ? NONE_WORD : top_val_nxt;
            out_nxt.min_value    = empty_nxt ? NONE_WORD : top_min_nxt;
            out_nxt.is_empty     = empty_nxt;
            out_nxt.status       = status;
            out_valid_nxt        = 1'b1;
          end
        end
      end
      S_POP_WAIT: begin
        top_val_nxt          = $signed(ram_rdata[EW-1:WORD_W]);
        top_min_nxt          = $signed(ram_rdata[WORD_W-1:0]);
        out_nxt.popped_value = popped_r;
        out_nxt.top_value    = $signed(ram_rdata[EW-1:WORD_W]);
        out_nxt.min_value    = $signed(ram_rdata[WORD_W-1:0]);
        out_nxt.is_empty     = 1'b0;
        out_nxt.status       = ST_OK;
        out_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
    popped_r  <= popped_nxt;
    out_r     <= out_nxt;
  end

  mts_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `MTS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `MTS_ASSERT_IMP(a_wait_slot_free, state_r == S_POP_WAIT, !out_valid_r)
  `MTS_ASSERT_IMP(a_empty_flag, out_valid_r, out_r.is_empty == (count_r == '0))
  `MTS_ASSERT_NXT(a_push_grows,
    in_valid && in_ready && (in_data.mode == MODE_PUSH) && (count_r != DEPTH_C),
    count_r == $past(count_r) + CW'(1))

endmodule

FILE: verif/mts_checker.sv
`timescale 1ns / 100ps

module mts_checker import mts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned results_pending
);

  logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
  logic signed [WORD_W-1:0] stack_mins  [STACK_DEPTH];
  int unsigned              stack_fill = 0;
  out_item_t                expected_results [$];
  int unsigned              mismatches = 0;
  int unsigned              pending_count = 0;

  assign fail_count      = mismatches;
  assign results_pending = pending_count;

  // Applies one operation to the shadow stack and returns the result it should produce.
  function automatic out_item_t apply_op(in_item_t op);
    out_item_t                res;
    logic signed [WORD_W-1:0] run_min;
    res.popped_value = NONE_WORD;
    res.top_value    = NONE_WORD;
    res.min_value    = NONE_WORD;
    res.status       = ST_OK;
    case (op.mode)
      MODE_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_PUSH_FULL;
        end else begin
          run_min = op.push_value;
          if (stack_fill > 0 && stack_mins[stack_fill-1] < run_min) begin
            run_min = stack_mins[stack_fill-1];
          end
          stack_words[stack_fill] = op.push_value;
          stack_mins[stack_fill]  = run_min;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          stack_fill--;
          res.popped_value = stack_words[stack_fill];
        end
      end
      default: ;
    endcase
    if (stack_fill > 0) begin
      res.top_value = stack_words[stack_fill-1];
      res.min_value = stack_mins[stack_fill-1];
    end
    res.is_empty = (stack_fill == 0);
    return res;
  endfunction

  function automatic void check_field(string field, logic signed [WORD_W-1:0] want,
                                      logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      stack_fill = 0;
      expected_results.delete();
    end else begin
      // Results leave only after their operation is accepted, so they are matched first.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction arrived with no operation outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", want.popped_value, out_data.popped_value);
          check_field("top_value", want.top_value, out_data.top_value);
          check_field("min_value", want.min_value, out_data.min_value);
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_data.is_empty));
          check_field("status", WORD_W'(want.status), WORD_W'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_op(in_data));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mts_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int unsigned fail_count;
  int unsigned results_pending;

  int unsigned issued_depth = 0;
  int unsigned sent_count = 0;
  bit          steady_feed = 1'b0;

  min_tracking_stack_top #(.STACK_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mts_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Half full-range words, with small values so that ties and -1 show up often.
  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom;
    if (roll < 8) return $signed($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return NONE_WORD;
      default: return '0;
    endcase
  endfunction

  task automatic send_op(input logic [1:0] mode, input logic signed [WORD_W-1:0] word);
    int unsigned gap;
    if (sent_count % 100 == 0) steady_feed = ($urandom_range(0, 3) == 0);
    gap = steady_feed ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {mode, word};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (mode == MODE_PUSH && issued_depth < DEPTH) issued_depth++;
    else if (mode == MODE_POP && issued_depth > 0) issued_depth--;
  endtask

  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned roll;
    logic [1:0]  mode;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) mode = MODE_PUSH;
    else if (roll < push_pct + pop_pct) mode = MODE_POP;
    else mode = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_QUERY;
    send_op(mode, pick_word());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(MODE_QUERY, '0);
    send_op(MODE_POP, 32'sd7);
    send_op(MODE_SPARE, WORD_MIN);
    send_op(MODE_PUSH, WORD_MAX);
    // A stored -1 looks like the empty marker; only is_empty tells them apart.
    send_op(MODE_PUSH, NONE_WORD);
    send_op(MODE_QUERY, WORD_MAX);
    send_op(MODE_PUSH, WORD_MIN);
    send_op(MODE_PUSH, '0);
    send_op(MODE_PUSH, 32'sd5);
    send_op(MODE_SPARE, 32'sd3);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH, NONE_WORD);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH, 32'sh5555_5555);
    send_op(MODE_PUSH, 32'shAAAA_AAAA);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);

    repeat (40) send_random(45, 40);
    while (issued_depth < DEPTH) send_random(95, 0);
    // Around the full stack, so that dropped pushes alternate with real ones.
    repeat (20) send_random(60, 25);
    repeat (30) send_random(30, 60);
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned taken;
    int unsigned stall_left;
    int unsigned cycle_count;
    bit          held;
    bit          steady_sink;
    taken       = 0;
    stall_left  = 0;
    cycle_count = 0;
    held        = 1'b0;
    steady_sink = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cycle_count++;
      if (out_valid && out_ready) taken++;
      if (cycle_count % 150 == 0) steady_sink = ($urandom_range(0, 3) == 0);
      if (!held && taken >= 40) begin
        // Long back-pressure while the sender keeps offering, so the input must stall.
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (steady_sink) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_ram.sv
hw/rtl/min_tracking_stack_top.sv
verif/mts_checker.sv
verif/tb_top.sv
